[hw/rtl/hue_window_background_whitener_defines.svh]
// Assertion macros for the checker file of the whitener block.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef HUE_WINDOW_BACKGROUND_WHITENER_DEFINES_SVH
`define HUE_WINDOW_BACKGROUND_WHITENER_DEFINES_SVH

// Property whose consequent holds in the same cycle.
`define HWBW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Property whose consequent holds in the next cycle.
`define HWBW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/hwbw_pkg.sv]
// ---------------------------------------------------------------------------
// hwbw_pkg
// Types, register indexes and defaults of the hue window background whitener.
// ---------------------------------------------------------------------------
package hwbw_pkg;

   // Default sizes handed to the top level parameters.
   localparam int WINDOW_DEFAULT   = 11;
   localparam int MAX_COLS_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT = 4096;

   // Configuration register indexes.
   localparam logic [1:0] REG_HUE_THRESHOLD   = 2'd0;
   localparam logic [1:0] REG_COUNT_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_FRAME_ROWS      = 2'd2;
   localparam logic [1:0] REG_FRAME_COLS      = 2'd3;

   // Register reset values.
   localparam logic [7:0]  HUE_THRESHOLD_RESET   = 8'd0;
   localparam logic [6:0]  COUNT_THRESHOLD_RESET = 7'd96;
   localparam logic [12:0] FRAME_ROWS_RESET      = 13'd480;
   localparam logic [10:0] FRAME_COLS_RESET      = 11'd640;

   localparam int CSR_DATA_W = 13;

   // Input transaction payload.
   typedef struct packed {
      logic       req_type;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_payload_type;

   // Result transaction payload.
   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_payload_type;

endpackage

[hw/rtl/hue_window_background_whitener.sv]
// ---------------------------------------------------------------------------
// hue_window_background_whitener
// Marks 11x11 windows rich in low-hue pixels white and replays the frame.
// ---------------------------------------------------------------------------
// Usage: pixels enter on the req_ channel in raster order (req_type 0) and
// leave on the rsp_ channel in raster order, ten rows plus ten pixels later,
// either unchanged or as pure white. Drain transactions (req_type 1) push out
// the pending tail once the whole frame has been taken in; frame_end marks
// the final pixel. The csr_ port is to write the four registers only while
// idle; the block itself does not enforce this. One transaction is worked
// on at a time. A drain that completes no result goes back to idle after its
// decode. A gray pixel is decoded, written and posted; any other pixel runs
// the shared bit-serial divider (one quotient bit per cycle) for its hue. A
// pixel that completes a window walks it to count it, compares the count, and
// walks it again when the window is marked white. A result runs the divider
// to split the output position into row and column, folds the row onto the
// line stores by a reciprocal product, reads them, loads the output register.
// Reset clears control and position registers; the line stores need no clearing.
// A finished result waits in the output register while the receiver stalls;
// the next transaction is taken meanwhile, and a later result holds until
// the register frees.
module hue_window_background_whitener #(
   parameter int WINDOW   = hwbw_pkg::WINDOW_DEFAULT,
   parameter int MAX_COLS = hwbw_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = hwbw_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hwbw_pkg::req_payload_type        req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hwbw_pkg::rsp_payload_type        rsp_data,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [hwbw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hwbw_pkg::*;

   localparam int DEPTH   = WINDOW * MAX_COLS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COL_W   = $clog2(MAX_COLS + 1);
   localparam int ROW_W   = $clog2(MAX_ROWS + 1);
   localparam int WIN_W   = $clog2(WINDOW);
   localparam int POS_W   = $clog2(MAX_ROWS * MAX_COLS);
   localparam int CNT_W   = $clog2(WINDOW * WINDOW + 1);
   localparam int DIV_W   = (POS_W > 14) ? POS_W : 14;
   localparam int DVS_W   = (COL_W > 8) ? COL_W : 8;
   localparam int DCNT_W  = $clog2(DIV_W + 1);

   // Reciprocal of WINDOW for folding the output row onto the line stores.
   localparam int     RECIP_S = DIV_W + $clog2(WINDOW);
   localparam int     RECIP_W = RECIP_S - $clog2(WINDOW) + 1;
   localparam int     PROD_W  = DIV_W + RECIP_W;
   localparam longint RECIP_M = ((longint'(1) << RECIP_S) + WINDOW - 1) / WINDOW;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_DEC     = 4'd1;
   localparam logic [3:0] ST_HDIV    = 4'd2;
   localparam logic [3:0] ST_WRITE   = 4'd3;
   localparam logic [3:0] ST_CNT     = 4'd4;
   localparam logic [3:0] ST_CNT_END = 4'd5;
   localparam logic [3:0] ST_CMP     = 4'd6;
   localparam logic [3:0] ST_MARK    = 4'd7;
   localparam logic [3:0] ST_POST    = 4'd8;
   localparam logic [3:0] ST_EMIT    = 4'd9;
   localparam logic [3:0] ST_EDIV1   = 4'd10;
   localparam logic [3:0] ST_EDIV2   = 4'd11;
   localparam logic [3:0] ST_ERD     = 4'd12;
   localparam logic [3:0] ST_EWT     = 4'd13;
   localparam logic [3:0] ST_EMOD    = 4'd14;

   // Line stores: color and hue share one entry, marks sit apart.
   logic [31:0] line_mem [DEPTH];
   logic        mark_mem [DEPTH];

   logic [3:0]          state_ff, state_in;
   logic [7:0]          hue_thr_ff;
   logic [6:0]          cnt_thr_ff;
   logic [12:0]         frame_rows_ff;
   logic [10:0]         frame_cols_ff;
   logic [ROW_W-1:0]    in_row_ff;
   logic [COL_W-1:0]    in_col_ff;
   logic [WIN_W-1:0]    in_rmod_ff;
   logic [POS_W-1:0]    out_pos_ff;
   req_payload_type     req_ff;
   logic [7:0]          hue_ff;
   logic                hneg_ff;
   logic [8:0]          hbase_ff;
   logic [POS_W-1:0]    idx_ff;
   logic [WIN_W-1:0]    wy_ff, wx_ff, wrow_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                rd_vld_ff;
   logic [7:0]          hue_rd_ff;
   logic [23:0]         color_rd_ff;
   logic                mark_rd_ff;
   logic [COL_W-1:0]    ocol_ff;
   logic [WIN_W-1:0]    ormod_ff;
   logic [DIV_W-1:0]    wq_ff;
   logic [PROD_W-1:0]   rprod;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_data_ff;

   // Shared divider registers.
   logic [DIV_W-1:0]    div_quo_ff;
   logic [DVS_W-1:0]    div_rem_ff;
   logic [DVS_W-1:0]    div_dvs_ff;
   logic [DCNT_W-1:0]   div_cnt_ff;
   logic                div_load;
   logic [DIV_W-1:0]    div_num;
   logic [DVS_W-1:0]    div_dvs;
   logic [DVS_W:0]      div_sh;
   logic                div_ge;
   logic                div_done;

   // Clamped frame sizes.
   logic [ROW_W-1:0]    rows_c;
   logic [COL_W-1:0]    cols_c;

   always_comb begin
      if (32'(frame_rows_ff) < WINDOW) begin
         rows_c = ROW_W'(WINDOW);
      end else if (32'(frame_rows_ff) > MAX_ROWS) begin
         rows_c = ROW_W'(MAX_ROWS);
      end else begin
         rows_c = ROW_W'(frame_rows_ff);
      end
      if (32'(frame_cols_ff) < WINDOW) begin
         cols_c = COL_W'(WINDOW);
      end else if (32'(frame_cols_ff) > MAX_COLS) begin
         cols_c = COL_W'(MAX_COLS);
      end else begin
         cols_c = COL_W'(frame_cols_ff);
      end
   end

   // Hue preparation: extremes, spread, numerator and sector base.
   logic [7:0]        mx, mn, spread;
   logic signed [8:0] hdiff;
   logic [7:0]        hmag;
   logic [13:0]       hnum;
   logic [8:0]        hbase;

   always_comb begin
      logic [7:0] r, g, b;
      r = req_ff.red_in;
      g = req_ff.green_in;
      b = req_ff.blue_in;
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      spread = mx - mn;
      if (mx == r) begin
         hdiff = $signed({1'b0, g}) - $signed({1'b0, b});
         hbase = 9'd0;
      end else if (mx == g) begin
         hdiff = $signed({1'b0, b}) - $signed({1'b0, r});
         hbase = 9'd120;
      end else begin
         hdiff = $signed({1'b0, r}) - $signed({1'b0, g});
         hbase = 9'd240;
      end
      hmag = hdiff[8] ? 8'(-hdiff) : hdiff[7:0];
      hnum = 14'(hmag) * 14'd60;
   end

   // Hue from the divider quotient, wrapped and halved.
   logic signed [10:0] hq, hsum, hwrap;

   always_comb begin
      hq    = $signed({1'b0, div_quo_ff[9:0]});
      hsum  = $signed({2'b0, hbase_ff}) + (hneg_ff ? -hq : hq);
      hwrap = (hsum < 0) ? hsum + 11'sd360 : hsum;
   end

   // Divider step: one quotient bit per cycle.
   always_comb begin
      div_sh   = {div_rem_ff, div_quo_ff[DIV_W-1]};
      div_ge   = div_sh >= {1'b0, div_dvs_ff};
      div_done = div_cnt_ff == '0;
   end

   // Output row times the reciprocal of WINDOW.
   always_comb begin
      rprod = PROD_W'(div_quo_ff) * PROD_W'(RECIP_M);
   end

   // Window addressing.
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_COLS);
   logic [COL_W-1:0]  win_col;
   logic [ADDR_W-1:0] win_addr, pix_addr, out_addr;
   logic              win_last;
   logic              eligible;

   always_comb begin
      win_col  = in_col_ff - COL_W'(WINDOW - 1) + COL_W'(wx_ff);
      win_addr = ADDR_W'(wrow_ff) * ROW_STRIDE + ADDR_W'(win_col);
      pix_addr = ADDR_W'(in_rmod_ff) * ROW_STRIDE + ADDR_W'(in_col_ff);
      out_addr = ADDR_W'(ormod_ff) * ROW_STRIDE + ADDR_W'(ocol_ff);
      win_last = (wy_ff == WIN_W'(WINDOW - 1)) && (wx_ff == WIN_W'(WINDOW - 1));
      eligible = (32'(in_row_ff) >= WINDOW - 1) && (32'(in_col_ff) >= WINDOW - 1);
   end

   // Emission check and end of frame.
   logic [POS_W:0] lag, total;
   logic           emit_due, is_last;

   always_comb begin
      lag      = (POS_W + 1)'(WINDOW - 1) * (POS_W + 1)'(cols_c) + (POS_W + 1)'(WINDOW - 1);
      total    = (POS_W + 1)'(rows_c) * (POS_W + 1)'(cols_c);
      emit_due = {1'b0, idx_ff} >= ({1'b0, out_pos_ff} + lag);
      is_last  = ({1'b0, out_pos_ff} + 1'b1) >= total;
   end

   logic req_accept;
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = state_ff != ST_IDLE;

   // Sequencer next state and divider loads.
   always_comb begin
      state_in = state_ff;
      div_load = 1'b0;
      div_num  = '0;
      div_dvs  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_DEC;
         end
         ST_DEC: begin
            if (in_row_ff >= rows_c) begin
               state_in = ST_EMIT;
            end else if (req_ff.req_type) begin
               state_in = ST_IDLE;
            end else if (spread == 8'd0) begin
               state_in = ST_WRITE;
            end else begin
               div_load = 1'b1;
               div_num  = DIV_W'(hnum);
               div_dvs  = DVS_W'(spread);
               state_in = ST_HDIV;
            end
         end
         ST_HDIV: begin
            if (div_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = eligible ? ST_CNT : ST_POST;
         end
         ST_CNT: begin
            if (win_last) state_in = ST_CNT_END;
         end
         ST_CNT_END: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = (count_ff >= CNT_W'(cnt_thr_ff)) ? ST_MARK : ST_POST;
         end
         ST_MARK: begin
            if (win_last) state_in = ST_POST;
         end
         ST_POST: begin
            state_in = emit_due ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            div_load = 1'b1;
            div_num  = DIV_W'(out_pos_ff);
            div_dvs  = DVS_W'(cols_c);
            state_in = ST_EDIV1;
         end
         ST_EDIV1: begin
            if (div_done) state_in = ST_EDIV2;
         end
         ST_EDIV2: begin
            state_in = ST_EMOD;
         end
         ST_EMOD: begin
            state_in = ST_ERD;
         end
         ST_ERD: begin
            state_in = ST_EWT;
         end
         ST_EWT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hue_thr_ff    <= HUE_THRESHOLD_RESET;
         cnt_thr_ff    <= COUNT_THRESHOLD_RESET;
         frame_rows_ff <= FRAME_ROWS_RESET;
         frame_cols_ff <= FRAME_COLS_RESET;
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         in_rmod_ff    <= '0;
         out_pos_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= state_ff == ST_CNT;

         // Register writes.
         if (csr_we) begin
            case (csr_index)
               REG_HUE_THRESHOLD:   hue_thr_ff    <= csr_wdata[7:0];
               REG_COUNT_THRESHOLD: cnt_thr_ff    <= csr_wdata[6:0];
               REG_FRAME_ROWS:      frame_rows_ff <= csr_wdata[12:0];
               REG_FRAME_COLS:      frame_cols_ff <= csr_wdata[10:0];
               default:             ;
            endcase
         end

         // Divider count.
         if (div_load) begin
            div_cnt_ff <= DCNT_W'(DIV_W);
         end else if (!div_done) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end

         // A row that is already full wraps before the transaction is decoded.
         if (req_accept && (in_col_ff >= cols_c)) begin
            in_col_ff  <= '0;
            in_row_ff  <= in_row_ff + 1'b1;
            in_rmod_ff <= (in_rmod_ff == WIN_W'(WINDOW - 1)) ? '0 : in_rmod_ff + 1'b1;
         end

         // Advance the input position after a pixel.
         if (state_ff == ST_POST) begin
            if (in_col_ff + 1'b1 >= cols_c) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + 1'b1;
               in_rmod_ff <= (in_rmod_ff == WIN_W'(WINDOW - 1)) ? '0 : in_rmod_ff + 1'b1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end

         // Output register.
         if (state_ff == ST_EWT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            if (is_last) begin
               in_row_ff  <= '0;
               in_col_ff  <= '0;
               in_rmod_ff <= '0;
               out_pos_ff <= '0;
            end else begin
               out_pos_ff <= out_pos_ff + 1'b1;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_accept) req_ff <= req_data;

      // Divider datapath.
      if (div_load) begin
         div_quo_ff <= div_num;
         div_rem_ff <= '0;
         div_dvs_ff <= div_dvs;
      end else if (!div_done) begin
         div_quo_ff <= {div_quo_ff[DIV_W-2:0], div_ge};
         div_rem_ff <= div_ge ? DVS_W'(div_sh - {1'b0, div_dvs_ff}) : div_sh[DVS_W-1:0];
      end

      // Hue capture.
      if (state_ff == ST_DEC) begin
         hue_ff   <= 8'd0;
         hneg_ff  <= hdiff[8];
         hbase_ff <= hbase;
      end
      if (state_ff == ST_HDIV && div_done) hue_ff <= hwrap[8:1];

      // Window walk counters.
      if (state_ff == ST_WRITE || state_ff == ST_CNT_END) begin
         wy_ff   <= '0;
         wx_ff   <= '0;
         wrow_ff <= (in_rmod_ff == WIN_W'(WINDOW - 1)) ? '0 : in_rmod_ff + 1'b1;
      end else if (state_ff == ST_CNT || state_ff == ST_MARK) begin
         if (wx_ff == WIN_W'(WINDOW - 1)) begin
            wx_ff   <= '0;
            wy_ff   <= wy_ff + 1'b1;
            wrow_ff <= (wrow_ff == WIN_W'(WINDOW - 1)) ? '0 : wrow_ff + 1'b1;
         end else begin
            wx_ff <= wx_ff + 1'b1;
         end
      end

      if (state_ff == ST_WRITE) begin
         idx_ff   <= POS_W'(in_row_ff) * POS_W'(cols_c) + POS_W'(in_col_ff);
         count_ff <= '0;
      end else if (rd_vld_ff && (hue_rd_ff < hue_thr_ff)) begin
         count_ff <= count_ff + 1'b1;
      end

      // Output position split: column from the divider, row folded by WINDOW.
      if (state_ff == ST_EDIV1 && div_done) ocol_ff <= COL_W'(div_rem_ff);
      if (state_ff == ST_EDIV2) wq_ff <= DIV_W'(rprod >> RECIP_S);
      if (state_ff == ST_EMOD) ormod_ff <= WIN_W'(div_quo_ff - wq_ff * DIV_W'(WINDOW));

      if (state_ff == ST_EWT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.red_out   <= mark_rd_ff ? 8'hFF : color_rd_ff[23:16];
         rsp_data_ff.green_out <= mark_rd_ff ? 8'hFF : color_rd_ff[15:8];
         rsp_data_ff.blue_out  <= mark_rd_ff ? 8'hFF : color_rd_ff[7:0];
         rsp_data_ff.frame_end <= is_last;
      end
   end

   // Line store ports.
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         line_mem[pix_addr] <= {req_ff.red_in, req_ff.green_in, req_ff.blue_in, hue_ff};
      end
      if (state_ff == ST_WRITE) begin
         mark_mem[pix_addr] <= 1'b0;
      end else if (state_ff == ST_MARK) begin
         mark_mem[win_addr] <= 1'b1;
      end
      if (state_ff == ST_CNT) hue_rd_ff <= line_mem[win_addr][7:0];
      if (state_ff == ST_ERD) begin
         color_rd_ff <= line_mem[out_addr][31:8];
         mark_rd_ff  <= mark_mem[out_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/hwbw_checker.sv]
// ---------------------------------------------------------------------------
// hwbw_checker
// Port-level checks of the whitener, bound to its top level.
// ---------------------------------------------------------------------------
`include "hue_window_background_whitener_defines.svh"

module hwbw_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input hwbw_pkg::rsp_payload_type rsp_data
);
   import hwbw_pkg::*;

   // A stalled result stays offered unchanged.
   `HWBW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // An accepted transaction keeps the block busy in the next cycle.
   `HWBW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // No new result appears in the cycle right after an accepted transaction.
   `HWBW_ASSERT_NOW(a_no_instant_rsp, $past(req_valid && !req_stall) && !$past(rsp_valid),
      !rsp_valid)

endmodule

bind hue_window_background_whitener hwbw_checker u_hwbw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
